// ===== sv/ssdd_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the smoothed serial DAC drive.
// No dependencies; every other file of the block imports this package.
package ssdd_pkg;

	localparam int SMOOTH_DEPTH = 8;
	localparam int RING_AW      = $clog2(SMOOTH_DEPTH);
	localparam int AVG_SHIFT    = $clog2(SMOOTH_DEPTH + 1) - 1;

	localparam int CMD_W   = 16;
	localparam int DB_W    = 13;
	localparam int LIM_W   = 12;
	localparam int SHAPE_W = 13;
	localparam int SUM_W   = SHAPE_W + RING_AW;
	localparam int WIDE_W  = 18;

	localparam int FRAME_BITS = 16;
	localparam int CNT_W      = $clog2(FRAME_BITS);
	localparam int DAC_W      = 12;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_LIMIT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DUTY_CEILING = 2'd2;

	localparam logic signed [SHAPE_W-1:0] CMD_LIMIT = 13'sd4095;
	localparam logic signed [DAC_W+1:0]   DAC_ZERO  = 14'sd2048;
	localparam logic signed [DAC_W+1:0]   DAC_TOP   = 14'sd4095;

	typedef struct packed {
		logic signed [DB_W-1:0] deadband;
		logic [LIM_W-1:0]       drive_limit;
		logic [LIM_W-1:0]       duty_ceiling;
	} cfg_t;

endpackage

// ===== sv/ssdd_shape.sv =====
`timescale 1ns / 1ps
// Input register and deadband/limit shaping stage of the DAC drive.
// Depends on ssdd_pkg.
module ssdd_shape
	import ssdd_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  cfg_t                      cfg,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [CMD_W-1:0]   drive_command,
	output logic                      valid_s2,
	input  logic                      take_s2,
	output logic signed [SHAPE_W-1:0] shaped_s2
);

	logic                     valid_s1;
	logic signed [CMD_W-1:0]  cmd_s1;
	logic                     acc_s2;
	logic signed [WIDE_W-1:0] v;
	logic signed [WIDE_W-1:0] db;
	logic signed [WIDE_W-1:0] mag;
	logic signed [WIDE_W-1:0] lim;
	logic signed [WIDE_W-1:0] d;
	logic [LIM_W-1:0]         lim_u;

	assign acc_s2   = !valid_s2 || take_s2;
	assign in_ready = !valid_s1 || acc_s2;

	always_comb begin
		v     = WIDE_W'(cmd_s1);
		db    = WIDE_W'(cfg.deadband);
		mag   = (v < 0) ? -v : v;
		lim_u = (cfg.drive_limit < cfg.duty_ceiling) ? cfg.drive_limit : cfg.duty_ceiling;
		lim   = $signed({{(WIDE_W - LIM_W){1'b0}}, lim_u});
		if (db < 0) begin
			d = (mag < -db) ? '0 : v;
		end else begin
			d = (v < 0) ? v - db : v + db;
		end
		if (d > lim) begin
			d = lim;
		end else if (d < -lim) begin
			d = -lim;
		end
		if (v == 0) begin
			d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (acc_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= drive_command;
		end
		if (valid_s1 && acc_s2) begin
			shaped_s2 <= d[SHAPE_W-1:0];
		end
	end

endmodule

// ===== sv/ssdd_ring.sv =====
`timescale 1ns / 1ps
// Ring of recent shaped commands with its running sum and the sum stage register.
// Depends on ssdd_pkg.
module ssdd_ring
	import ssdd_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      valid_s2,
	input  logic signed [SHAPE_W-1:0] shaped_s2,
	output logic                      take_s2,
	output logic                      valid_s3,
	input  logic                      take_s3,
	output logic signed [SUM_W-1:0]   sum_s3
);

	logic signed [SHAPE_W-1:0] ring_q [SMOOTH_DEPTH];
	logic [RING_AW-1:0]        pos_q;
	logic signed [SUM_W-1:0]   sum_q;
	logic signed [SUM_W-1:0]   sum_next;
	logic                      acc_s3;
	logic                      upd;

	assign acc_s3  = !valid_s3 || take_s3;
	assign take_s2 = acc_s3;
	assign upd     = valid_s2 && acc_s3;
	assign sum_next = sum_q - SUM_W'(ring_q[pos_q]) + SUM_W'(shaped_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SMOOTH_DEPTH; i++) begin
				ring_q[i] <= '0;
			end
			pos_q    <= '0;
			sum_q    <= '0;
			valid_s3 <= 1'b0;
		end else begin
			if (acc_s3) begin
				valid_s3 <= valid_s2;
			end
			if (upd) begin
				ring_q[pos_q] <= shaped_s2;
				sum_q         <= sum_next;
				if (pos_q == RING_AW'(SMOOTH_DEPTH - 1)) begin
					pos_q <= '0;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			sum_s3 <= sum_next;
		end
	end

endmodule

// ===== sv/ssdd_serial.sv =====
`timescale 1ns / 1ps
// Average, DAC code conversion and MSB-first frame shifter of the DAC drive.
// Depends on ssdd_pkg.
module ssdd_serial
	import ssdd_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      valid_s3,
	input  logic signed [SUM_W-1:0]   sum_s3,
	output logic                      take_s3,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      serial_bit,
	output logic                      frame_last,
	output logic signed [SHAPE_W-1:0] smoothed_command
);

	logic [FRAME_BITS-1:0]     shift_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      busy_q;
	logic signed [SUM_W-1:0]   sh;
	logic signed [SHAPE_W-1:0] avg;
	logic signed [DAC_W+1:0]   u;
	logic [DAC_W-1:0]          code;
	logic                      out_fire;
	logic                      load;

	always_comb begin
		sh = sum_s3 >>> AVG_SHIFT;
		if (sh > SUM_W'(CMD_LIMIT)) begin
			avg = CMD_LIMIT;
		end else if (sh < -SUM_W'(CMD_LIMIT)) begin
			avg = -CMD_LIMIT;
		end else begin
			avg = sh[SHAPE_W-1:0];
		end
		u = (DAC_W + 2)'(avg) + DAC_ZERO;
		if (u < 0) begin
			code = '0;
		end else if (u > DAC_TOP) begin
			code = DAC_TOP[DAC_W-1:0];
		end else begin
			code = u[DAC_W-1:0];
		end
	end

	assign out_valid  = busy_q;
	assign serial_bit = shift_q[FRAME_BITS-1];
	assign frame_last = (cnt_q == CNT_W'(FRAME_BITS - 1));
	assign out_fire   = out_valid && out_ready;
	assign take_s3    = !busy_q || (out_fire && frame_last);
	assign load       = valid_s3 && take_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (out_fire) begin
				if (frame_last) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			shift_q          <= FRAME_BITS'({code, 2'b00});
			smoothed_command <= avg;
		end else if (out_fire) begin
			shift_q <= {shift_q[FRAME_BITS-2:0], 1'b0};
		end
	end

endmodule

// ===== sv/smoothed_serial_dac_drive_unit.sv =====
`timescale 1ns / 1ps
// Top level of the smoothed serial DAC drive: configuration registers and stage wiring.
// Depends on ssdd_pkg, ssdd_shape, ssdd_ring and ssdd_serial.
//
// Each accepted drive command produces sixteen output items, the bits of a 16-bit DAC
// frame sent most significant first; the frame shifter delivers one bit per cycle while
// out_ready is high. A command passes an input register, the shaping register and the
// ring sum register before its frame is loaded into the shift register, from which the
// first bit appears; the next commands are taken into these stages while a frame is
// still being shifted out. The reported smoothed command is the same on all sixteen
// items of a frame. Configuration writes take effect on the next item shaped and should
// be made while the block is idle.
module smoothed_serial_dac_drive_unit
	import ssdd_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [CMD_W-1:0]   drive_command,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      serial_bit,
	output logic                      frame_last,
	output logic signed [SHAPE_W-1:0] smoothed_command
);

	cfg_t                      cfg_q;
	logic                      valid_s2;
	logic                      take_s2;
	logic signed [SHAPE_W-1:0] shaped_s2;
	logic                      valid_s3;
	logic                      take_s3;
	logic signed [SUM_W-1:0]   sum_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.deadband     <= '0;
			cfg_q.drive_limit  <= '1;
			cfg_q.duty_ceiling <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEADBAND:     cfg_q.deadband     <= $signed(cfg_data[DB_W-1:0]);
				CFG_DRIVE_LIMIT:  cfg_q.drive_limit  <= cfg_data[LIM_W-1:0];
				CFG_DUTY_CEILING: cfg_q.duty_ceiling <= cfg_data[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	ssdd_shape u_shape (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.drive_command (drive_command),
		.valid_s2      (valid_s2),
		.take_s2       (take_s2),
		.shaped_s2     (shaped_s2)
	);

	ssdd_ring u_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s2  (valid_s2),
		.shaped_s2 (shaped_s2),
		.take_s2   (take_s2),
		.valid_s3  (valid_s3),
		.take_s3   (take_s3),
		.sum_s3    (sum_s3)
	);

	ssdd_serial u_serial (
		.clk              (clk),
		.arst_n           (arst_n),
		.valid_s3         (valid_s3),
		.sum_s3           (sum_s3),
		.take_s3          (take_s3),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.serial_bit       (serial_bit),
		.frame_last       (frame_last),
		.smoothed_command (smoothed_command)
	);

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for smoothed_serial_dac_drive_unit: drive commands are predicted
// as 16-bit DAC frames and every serial output item is checked field by field.
// Depends on ssdd_pkg and the block's RTL; needs no files or arguments.
module tb_top
	import ssdd_pkg::*;
();

	localparam int HALF_PERIOD = 6;
	localparam int IDLE_LIMIT = 2000;
	localparam int AVG_SH = $clog2(SMOOTH_DEPTH + 1) - 1;

	typedef struct packed {
		logic serial_bit;
		logic frame_last;
		logic signed [SHAPE_W-1:0] smoothed;
	} dac_bit_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_DEADBAND;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [CMD_W-1:0] drive_command = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic serial_bit;
	logic frame_last;
	logic signed [SHAPE_W-1:0] smoothed_command;

	logic signed [DB_W-1:0] deadband_q = '0;
	logic [LIM_W-1:0] drive_limit_q = '1;
	logic [LIM_W-1:0] duty_ceiling_q = '1;
	int cmd_ring [SMOOTH_DEPTH];
	int ring_wr;
	int ring_total;

	logic signed [CMD_W-1:0] pending_cmds [$];
	dac_bit_t dac_frames [$];
	dac_bit_t want_bit;
	int errors = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	int gap_left = 0;
	bit sender_gaps = 1'b0;
	bit rcv_stalls = 1'b0;
	logic [15:0] stall_word = '1;
	logic [3:0] stall_pos = '0;

	smoothed_serial_dac_drive_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.drive_command(drive_command),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.serial_bit(serial_bit),
		.frame_last(frame_last),
		.smoothed_command(smoothed_command)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic int shape_drive(input int v);
		int d;
		int db;
		int lim;
		db = int'(deadband_q);
		lim = (drive_limit_q < duty_ceiling_q) ? int'(drive_limit_q) : int'(duty_ceiling_q);
		if (v == 0) return 0;
		d = v;
		if (db < 0) begin
			if ((v < 0 ? -v : v) < -db) d = 0;
		end else begin
			d = (v > 0) ? v + db : v - db;
		end
		if (d > lim) d = lim;
		if (d < -lim) d = -lim;
		return d;
	endfunction

	function automatic void predict_frame(input logic signed [CMD_W-1:0] cmd);
		int d;
		int avg;
		int dac;
		logic [15:0] frame;
		dac_bit_t e;
		d = shape_drive(int'(cmd));
		ring_total = ring_total - cmd_ring[ring_wr] + d;
		cmd_ring[ring_wr] = d;
		ring_wr = (ring_wr + 1) % SMOOTH_DEPTH;
		avg = ring_total >>> AVG_SH;
		if (avg > CMD_LIMIT) avg = CMD_LIMIT;
		if (avg < -CMD_LIMIT) avg = -CMD_LIMIT;
		dac = avg + DAC_ZERO;
		if (dac < 0) dac = 0;
		if (dac > DAC_TOP) dac = DAC_TOP;
		frame = 16'(dac << 2);
		for (int k = 0; k < FRAME_BITS; k++) begin
			e.serial_bit = frame[FRAME_BITS - 1 - k];
			e.frame_last = (k == FRAME_BITS - 1);
			e.smoothed = avg[SHAPE_W-1:0];
			dac_frames.push_back(e);
		end
	endfunction

	function automatic logic signed [CMD_W-1:0] rand_cmd();
		int db;
		int v;
		db = int'(deadband_q);
		if (db < 0) db = -db;
		case ($urandom_range(0, 7))
			0: v = $urandom;
			1: v = 0;
			2: v = $urandom_range(0, 8190) - 4095;
			3: begin
				v = db + $urandom_range(0, 2) - 1;
				if ($urandom_range(0, 1)) v = -v;
			end
			4: v = $urandom_range(0, 65535) - 32768;
			default: v = $urandom_range(0, 1600) - 800;
		endcase
		return v[CMD_W-1:0];
	endfunction

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_DEADBAND: deadband_q = value[DB_W-1:0];
			CFG_DRIVE_LIMIT: drive_limit_q = value[LIM_W-1:0];
			CFG_DUTY_CEILING: duty_ceiling_q = value[LIM_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_registers(input int db, input int dl, input int dc);
		cfg_write(CFG_DEADBAND, db);
		cfg_write(CFG_DRIVE_LIMIT, dl);
		cfg_write(CFG_DUTY_CEILING, dc);
	endtask

	task automatic drain();
		do @(posedge clk);
		while (pending_cmds.size() != 0 || in_valid || dac_frames.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			drive_command <= '0;
		end else begin
			if (in_valid && in_ready) begin
				predict_frame(drive_command);
				if (burst_left > 0) burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 10);
					if (sender_gaps) gap_left = $urandom_range(0, 20);
				end
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_cmds.size() != 0) begin
					in_valid <= 1'b1;
					drive_command <= pending_cmds.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (dac_frames.size() == 0) begin
					$display("%0t: unexpected item, expected none, actual bit=%b last=%b avg=%0d",
						$time, serial_bit, frame_last, smoothed_command);
					errors++;
				end else begin
					want_bit = dac_frames.pop_front();
					if (serial_bit !== want_bit.serial_bit) begin
						$display("%0t: serial_bit mismatch, expected %b, actual %b",
							$time, want_bit.serial_bit, serial_bit);
						errors++;
					end
					if (frame_last !== want_bit.frame_last) begin
						$display("%0t: frame_last mismatch, expected %b, actual %b",
							$time, want_bit.frame_last, frame_last);
						errors++;
					end
					if (smoothed_command !== want_bit.smoothed) begin
						$display("%0t: smoothed_command mismatch, expected %0d, actual %0d",
							$time, want_bit.smoothed, smoothed_command);
						errors++;
					end
				end
			end
			if (stall_pos == 4'd15) begin
				if ($urandom_range(0, 3) == 0) stall_word = 16'($urandom & $urandom);
				else stall_word = 16'($urandom | $urandom);
			end
			stall_pos <= stall_pos + 4'd1;
			out_ready <= rcv_stalls ? stall_word[stall_pos] : 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		for (int i = 0; i < SMOOTH_DEPTH; i++) cmd_ring[i] = 0;
		ring_wr = 0;
		ring_total = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Reset registers: zero deadband, saturation of the frame at both ends, ring wrap.
		pending_cmds.push_back(CMD_W'(0));
		repeat (5) pending_cmds.push_back(CMD_W'(32767));
		repeat (8) pending_cmds.push_back(CMD_W'(-32768));
		pending_cmds.push_back(CMD_W'(1));
		pending_cmds.push_back(CMD_W'(-1));
		pending_cmds.push_back(16'h5555);
		pending_cmds.push_back(16'hAAAA);
		drain();

		// A negative deadband zeroes commands below its magnitude.
		set_registers(-100, 3000, 4095);
		pending_cmds.push_back(CMD_W'(99));
		pending_cmds.push_back(CMD_W'(-99));
		pending_cmds.push_back(CMD_W'(100));
		pending_cmds.push_back(CMD_W'(-100));
		pending_cmds.push_back(CMD_W'(0));
		drain();

		set_registers(4095, 4095, 1000);
		pending_cmds.push_back(CMD_W'(1));
		pending_cmds.push_back(CMD_W'(-1));
		drain();

		// An effective limit of zero forces every command to zero.
		set_registers(0, 0, 4095);
		pending_cmds.push_back(CMD_W'(1234));
		drain();
		set_registers(0, 4095, 0);
		pending_cmds.push_back(CMD_W'(-1234));
		drain();

		for (int p = 0; p < 5; p++) begin
			case (p)
				0: set_registers(-4095, 4095, 4095);
				2: set_registers(0, 4095, $urandom_range(0, 4095));
				default: begin
					if ($urandom_range(0, 1))
						set_registers($urandom_range(0, 600) - 300, $urandom_range(0, 4095),
							$urandom_range(0, 4095));
					else
						set_registers($urandom_range(0, 8190) - 4095, $urandom_range(0, 4095),
							$urandom_range(0, 4095));
				end
			endcase
			sender_gaps = (p != 0);
			rcv_stalls = (p == 1) || (p >= 3);
			repeat (37) pending_cmds.push_back(rand_cmd());
			drain();
		end

		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
